@@ rtl/core/spm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types, character codes and the word-boundary group table for the
// search pattern escape mapper.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Word-boundary group: "([^a-zA-Z0-9_]|" then '^' or '$', then ')'
  localparam int unsigned GROUP_LEN = 17;
  localparam int unsigned IDX_W     = $clog2(GROUP_LEN);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_PIPE   = "|";
  localparam logic [7:0] CH_QUEST  = "?";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_RBRACK = "]";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_CARET  = "^";
  localparam logic [7:0] CH_DOLLAR = "$";

  typedef struct packed {
    logic [7:0] pattern_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_out;
    logic       begin_word;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,  // held backslash, nothing to emit
    CMD_ONE   = 2'd1,  // the character alone
    CMD_TWO   = 2'd2,  // backslash, then the character
    CMD_GROUP = 2'd3   // 17-character word-boundary group
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] ch;
    logic       last;
    logic       begin_word;
  } cmd_t;

  function automatic logic [7:0] group_char(input logic [IDX_W-1:0] idx,
                                            input logic is_end);
    logic [7:0] c;
    case (idx)
      5'd0:  c = "(";
      5'd1:  c = "[";
      5'd2:  c = "^";
      5'd3:  c = "a";
      5'd4:  c = "-";
      5'd5:  c = "z";
      5'd6:  c = "A";
      5'd7:  c = "-";
      5'd8:  c = "Z";
      5'd9:  c = "0";
      5'd10: c = "-";
      5'd11: c = "9";
      5'd12: c = "_";
      5'd13: c = "]";
      5'd14: c = "|";
      5'd15: c = is_end ? CH_DOLLAR : CH_CARET;
      5'd16: c = ")";
      default: c = ")";
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/search_pattern_escape_mapper.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// search_pattern_escape_mapper
// Translates a search pattern, one character per transaction, into the
// characters of the equivalent regular expression.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one pattern character per transaction, last_char marks the end.
//   out_*  : one translated character per transaction; last_out marks the
//            final character of the pattern, begin_word reports a leading
//            begin-word escape.
//   cfg_*  : writes magic_mode; cfg_ready_o is always high. Write only while
//            idle.
// Path: an accepted character is written into the queue; the output register
//   then loads it from the queue head and raises out_valid_o.
// Throughput: one output character per cycle while a command is queued and
//   the output is not stalled, set by the back end expander. A character
//   gives itself, an escaped one a backslash then the character, and a
//   word-boundary escape the 17-character group; a held backslash gives no
//   output. The front keeps accepting while the queue has room.
// Reset: clears escape/position state, empties the queue, drops out_valid,
//   and sets magic_mode to 1.
// Stall: out_data_o holds while out_ready_i is low; the queue fills, then
//   in_ready_o drops until the back end drains an entry.
// ----------------------------------------------------------------------------
module search_pattern_escape_mapper #(
  parameter int unsigned QueueDepth = spm_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire spm_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output spm_pkg::out_item_t      out_data_o
);
  import spm_pkg::*;

  // front -> queue
  logic push;
  cmd_t push_cmd;
  logic q_full;
  // queue -> back
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  // Config register lives in the front; it is written any cycle.
  assign cfg_ready_o = 1'b1;

  // Classifier: escape tracking, begin-word flag, emit command per char.
  spm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Decouples the classifier from long group expansions.
  spm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  // Expander: one output character per cycle into the output register, unless stalled.
  spm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

@@ rtl/core/spm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spm_front
// Accepts pattern characters, tracks escape and position state, and turns
// each character into an emit command for the back end.
// ----------------------------------------------------------------------------
module spm_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  input  wire logic            cfg_data_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire spm_pkg::in_item_t in_data_i,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output spm_pkg::cmd_t        cmd_o
);
  import spm_pkg::*;

  logic       magic_q;
  logic       esc_q, esc_d;
  logic [1:0] seen_q, seen_d;
  logic       bw_q, bw_d;
  logic       accept;
  logic [7:0] c;
  logic       is_always, is_magic, is_drop;
  cmd_kind_e  kind;

  assign c      = in_data_i.pattern_char;
  assign accept = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;

  assign is_always = (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_PIPE) ||
                     (c == CH_QUEST) || (c == CH_PLUS);
  assign is_magic  = (c == CH_DOT) || (c == CH_STAR) || (c == CH_LBRACK) ||
                     (c == CH_RBRACK);
  assign is_drop   = is_always || is_magic || (c == CH_SLASH);

  always_comb begin
    kind   = CMD_ONE;
    esc_d  = esc_q;
    bw_d   = (seen_q == 2'd0) ? 1'b0 : bw_q;
    seen_d = (seen_q == 2'd2) ? seen_q : seen_q + 2'd1;
    if (esc_q) begin
      esc_d = 1'b0;
      if (seen_q == 2'd1 && c == CH_LT) begin
        bw_d = 1'b1;
      end
      if (c == CH_LT || c == CH_GT) begin
        kind = CMD_GROUP;
      end else if ((magic_q && is_magic) || !is_drop) begin
        kind = CMD_TWO;
      end
    end else if (c == CH_BSLASH) begin
      if (in_data_i.last_char) begin
        kind = CMD_ONE;
      end else begin
        kind  = CMD_NONE;
        esc_d = 1'b1;
      end
    end else if (is_always || (!magic_q && is_magic)) begin
      kind = CMD_TWO;
    end
    if (in_data_i.last_char) begin
      esc_d  = 1'b0;
      seen_d = 2'd0;
    end
  end

  assign push_o          = accept && (kind != CMD_NONE);
  assign cmd_o.kind       = kind;
  assign cmd_o.ch         = c;
  assign cmd_o.last       = in_data_i.last_char;
  assign cmd_o.begin_word = bw_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= 1'b1;
      esc_q   <= 1'b0;
      seen_q  <= 2'd0;
      bw_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        magic_q <= cfg_data_i;
      end
      if (accept) begin
        esc_q  <= esc_d;
        seen_q <= seen_d;
        bw_q   <= bw_d;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/spm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spm_queue
// Small command queue between front and back end.
// ----------------------------------------------------------------------------
module spm_queue #(
  parameter int unsigned Depth = spm_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire spm_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output spm_pkg::cmd_t      cmd_o
);
  import spm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/spm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spm_back
// Expands one command into its output characters, one per cycle while the
// output register is free or read, into a registered output stage.
// ----------------------------------------------------------------------------
module spm_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire spm_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output spm_pkg::out_item_t out_data_o
);
  import spm_pkg::*;

  localparam logic [IDX_W-1:0] GroupLast = IDX_W'(GROUP_LEN - 1);

  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  out_item_t        out_q;
  logic             load, is_final;
  logic [7:0]       cur_char;

  assign load = cmd_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    cur_char = cmd_i.ch;
    is_final = 1'b1;
    case (cmd_i.kind)
      CMD_TWO: begin
        cur_char = (idx_q == '0) ? CH_BSLASH : cmd_i.ch;
        is_final = (idx_q != '0);
      end
      CMD_GROUP: begin
        cur_char = group_char(idx_q, cmd_i.ch == CH_GT);
        is_final = (idx_q == GroupLast);
      end
      default: begin
        cur_char = cmd_i.ch;
        is_final = 1'b1;
      end
    endcase
  end

  assign pop_o       = load && is_final;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_char   <= cur_char;
      out_q.last_out   <= cmd_i.last && is_final;
      out_q.begin_word <= cmd_i.begin_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_final ? '0 : idx_q + 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/spm_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spm_checker
// Port-level checks for the search pattern escape mapper, bound to the top.
// ----------------------------------------------------------------------------
module spm_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_ready_o,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire spm_pkg::out_item_t out_data_o
);
  import spm_pkg::*;

  // Output register is cleared by the reset.
  a_reset_clears_out: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("out_valid_o high during reset");

  // Coming out of reset the queue is empty and nothing is pending.
  a_ready_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (in_ready_o && !out_valid_o && cfg_ready_o))
    else $error("block not idle after reset release");

  // A stalled output transaction holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("output changed while stalled");

endmodule

bind search_pattern_escape_mapper spm_checker u_spm_checker (.*);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for search_pattern_escape_mapper. A short table of
// hand-picked characters runs first, with the expected output typed in where
// it is obvious. Random patterns follow, checked against a cycle-free
// translation predictor. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import spm_pkg::*;

  // Run control
  localparam int PHASE_ITEMS = 50;    // minimum random characters per phase
  localparam int NUM_PHASES  = 6;
  localparam int DIR_ROWS    = 25;
  localparam int LONG_HOLD   = 150;   // receiver hold-off for the pressure test
  localparam int DRAIN_SLACK = 8;     // cycles after the last result before a cfg write
  localparam int END_SLACK   = 20;    // cycles to catch stray results at the end
  localparam int WATCHDOG    = 2000;  // cycles with no transaction at all

  // Body of the word-boundary group; '^' or '$' and ')' follow
  localparam logic [8*15-1:0] WORD_CLASS = "([^a-zA-Z0-9_]|";

  // One row of the directed table. When 'typed' is set, the expected output
  // is exp_str (exp_len chars, leftmost first) with begin_word = bw.
  typedef struct packed {
    logic [7:0]   ch;
    logic         last;
    logic         typed;
    logic         bw;
    logic [4:0]   exp_len;
    logic [135:0] exp_str;
  } dir_row_t;

  logic      clk_i;
  logic      rst_n     = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      cfg_ready_o;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  // Predictor state
  logic       magic_on;
  logic       esc_held;
  logic [1:0] seen_count;
  logic       bw_flag;

  out_item_t  pending_chars[$];    // expected output chars, oldest first
  out_item_t  step_chars[$];       // chars produced by the last predicted step
  int         mismatch_count = 0;
  int         items_sent     = 0;
  int         idle_cycles    = 0;
  bit         no_idle        = 1'b0;
  bit         hold_request   = 1'b0;

  search_pattern_escape_mapper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // --------------------------------------------------------------------------
  // Character classes
  // --------------------------------------------------------------------------
  // Always special when unescaped: gets a backslash in front
  function automatic bit is_always_escaped(input logic [7:0] c);
    case (c)
      CH_LPAREN, CH_RPAREN, CH_PIPE, CH_QUEST, CH_PLUS: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Special only in magic syntax
  function automatic bit is_magic_char(input logic [7:0] c);
    case (c)
      CH_DOT, CH_STAR, CH_LBRACK, CH_RBRACK: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Escaped chars that lose their backslash (unless magic keeps it)
  function automatic bit is_droppable(input logic [7:0] c);
    return (c == CH_SLASH) || is_always_escaped(c) || is_magic_char(c);
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: translates one accepted pattern char into step_chars and
  // advances the escape / position / begin-word state.
  // --------------------------------------------------------------------------
  function automatic void predict_translation(input in_item_t it);
    logic [7:0] c;
    logic [7:0] chars[$];
    int         i;
    c = it.pattern_char;
    step_chars.delete();
    if (seen_count == 2'd0) bw_flag = 1'b0;  // first char of a new pattern

    if (esc_held) begin
      esc_held = 1'b0;
      // backslash-< as the opening escape marks a begin-word pattern
      if (seen_count == 2'd1 && c == CH_LT) bw_flag = 1'b1;
      if (c == CH_LT || c == CH_GT) begin
        for (i = 0; i < 15; i++) chars.push_back(WORD_CLASS[8*(14-i) +: 8]);
        chars.push_back((c == CH_LT) ? CH_CARET : CH_DOLLAR);
        chars.push_back(CH_RPAREN);
      end else begin
        if ((magic_on && is_magic_char(c)) || !is_droppable(c)) chars.push_back(CH_BSLASH);
        chars.push_back(c);
      end
    end else if (c == CH_BSLASH) begin
      // a trailing lone backslash is emitted as itself, otherwise held
      if (it.last_char) chars.push_back(CH_BSLASH);
      else esc_held = 1'b1;
    end else begin
      if (is_always_escaped(c) || (!magic_on && is_magic_char(c))) chars.push_back(CH_BSLASH);
      chars.push_back(c);
    end

    if (seen_count < 2'd2) seen_count = seen_count + 2'd1;

    for (i = 0; i < chars.size(); i++)
      step_chars.push_back('{out_char: chars[i],
                             last_out: it.last_char && (i == chars.size() - 1),
                             begin_word: bw_flag});

    if (it.last_char) begin
      esc_held   = 1'b0;
      seen_count = 2'd0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Directed table (reset config: magic syntax on)
  // --------------------------------------------------------------------------
  function automatic dir_row_t typed_row(input logic [7:0] ch, input logic last,
                                         input logic bw, input int len,
                                         input logic [135:0] str);
    dir_row_t r;
    r.ch      = ch;
    r.last    = last;
    r.typed   = 1'b1;
    r.bw      = bw;
    r.exp_len = 5'(len);
    r.exp_str = str;
    return r;
  endfunction

  function automatic dir_row_t directed_row(input int idx);
    dir_row_t r;
    r = '0;
    case (idx)
      // begin-word escape at the start, flag stays up for the whole pattern
      0:  r = typed_row(CH_BSLASH, 1'b0, 1'b0, 0, '0);
      1:  r = typed_row(CH_LT,     1'b0, 1'b1, 17, "([^a-zA-Z0-9_]|^)");
      2:  r = typed_row("x",       1'b1, 1'b1, 1,  "x");
      // always-special chars, new pattern clears the flag
      3:  r = typed_row(CH_LPAREN, 1'b0, 1'b0, 2, "\\(");
      4:  r = typed_row(CH_RPAREN, 1'b0, 1'b0, 2, "\\)");
      5:  r = typed_row(CH_PIPE,   1'b0, 1'b0, 2, "\\|");
      6:  r = typed_row(CH_QUEST,  1'b0, 1'b0, 2, "\\?");
      7:  r = typed_row(CH_PLUS,   1'b1, 1'b0, 2, "\\+");
      // magic chars pass through untouched in magic syntax
      8:  r = typed_row(CH_DOT,    1'b0, 1'b0, 1, ".");
      9:  r = typed_row(CH_STAR,   1'b0, 1'b0, 1, "*");
      10: r = typed_row(CH_LBRACK, 1'b0, 1'b0, 1, "[");
      11: r = typed_row(CH_RBRACK, 1'b1, 1'b0, 1, "]");
      // escapes: kept for magic chars, dropped for '/', group for '>',
      // kept for ordinary letters, lone trailing backslash
      12: r = typed_row(CH_BSLASH, 1'b0, 1'b0, 0, '0);
      13: r = typed_row(CH_DOT,    1'b0, 1'b0, 2, "\\.");
      14: r = typed_row(CH_BSLASH, 1'b0, 1'b0, 0, '0);
      15: r = typed_row(CH_SLASH,  1'b0, 1'b0, 1, "/");
      16: r = typed_row(CH_BSLASH, 1'b0, 1'b0, 0, '0);
      17: r = typed_row(CH_GT,     1'b0, 1'b0, 17, "([^a-zA-Z0-9_]|$)");
      18: r = typed_row(CH_BSLASH, 1'b0, 1'b0, 0, '0);
      19: r = typed_row("n",       1'b0, 1'b0, 2, "\\n");
      20: r = typed_row(CH_BSLASH, 1'b1, 1'b0, 1, "\\");
      // char code extremes and the zero char (predictor-checked)
      21: r = typed_row(8'h01,     1'b0, 1'b0, 1, 136'h01);
      22: begin
        r.ch   = 8'h00;
        r.last = 1'b0;
      end
      23: r = typed_row(8'hFF,     1'b1, 1'b0, 1, 136'hFF);
      // pattern that is nothing but a backslash
      24: r = typed_row(CH_BSLASH, 1'b1, 1'b0, 1, "\\");
      default: r = '0;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus helpers
  // --------------------------------------------------------------------------
  // Idle stretch: mostly short, a few long
  function automatic int pick_idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] random_pattern_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return CH_BSLASH;
    if (r < 55) begin
      case ($urandom_range(0, 13))
        0:  return CH_LPAREN;
        1:  return CH_RPAREN;
        2:  return CH_PIPE;
        3:  return CH_QUEST;
        4:  return CH_PLUS;
        5:  return CH_DOT;
        6:  return CH_STAR;
        7:  return CH_LBRACK;
        8:  return CH_RBRACK;
        9:  return CH_SLASH;
        10: return CH_LT;
        11: return CH_GT;
        12: return CH_CARET;
        default: return CH_DOLLAR;
      endcase
    end
    if (r < 57) return 8'h00;
    return 8'($urandom_range(1, 255));
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Called and returns at a falling edge; in_valid stays high on
  // return so back-to-back transactions need no extra assignment.
  // --------------------------------------------------------------------------
  task automatic send_char(input dir_row_t row);
    int       gap;
    in_item_t it;
    int       i;
    gap = (no_idle || $urandom_range(0, 99) < 60) ? 0 : pick_idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    it.pattern_char = row.ch;
    it.last_char    = row.last;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    // transaction accepted: advance the predictor, queue what it expects
    predict_translation(it);
    if (row.typed) begin
      for (i = 0; i < row.exp_len; i++)
        pending_chars.push_back('{out_char: row.exp_str[8*(row.exp_len-1-i) +: 8],
                                  last_out: row.last && (i == row.exp_len - 1),
                                  begin_word: row.bw});
    end else begin
      foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random_pattern();
    int       len;
    bit       word_start;
    dir_row_t r;
    int       k;
    len        = $urandom_range(1, 8);
    // a fifth of the patterns longer than one char open with the begin-word escape
    word_start = (len >= 2) && ($urandom_range(0, 4) == 0);
    for (k = 0; k < len; k++) begin
      r      = '0;
      r.last = (k == len - 1);
      if (word_start && k == 0)      r.ch = CH_BSLASH;
      else if (word_start && k == 1) r.ch = CH_LT;
      else                           r.ch = random_pattern_char();
      send_char(r);
    end
  endtask

  // Sender pause until every expected char is out, then slack for a held
  // backslash that produces nothing. Returns at a falling edge.
  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(negedge clk_i);
  endtask

  // Only issued while idle; starts and returns at a falling edge
  task automatic write_magic(input logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    magic_on = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random back-pressure, plus the long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : drive_out_ready
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (no_idle || $urandom_range(0, 99) < 65) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = pick_idle_len() - 1;
      end
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin : check_output
    out_item_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: expected no output, got char=%h last=%b bw=%b", $time,
                 out_data_o.out_char, out_data_o.last_out, out_data_o.begin_word);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_data_o !== want) begin
          $display("%0t: mismatch expected char=%h last=%b bw=%b, got char=%h last=%b bw=%b",
                   $time, want.out_char, want.last_out, want.begin_word,
                   out_data_o.out_char, out_data_o.last_out, out_data_o.begin_word);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any transaction on any port restarts the count
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    int row_idx;
    int phase;
    int target;
    magic_on   = 1'b1;
    esc_held   = 1'b0;
    seen_count = 2'd0;
    bw_flag    = 1'b0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed table at the reset setting
    for (row_idx = 0; row_idx < DIR_ROWS; row_idx++) send_char(directed_row(row_idx));
    in_valid <= 1'b0;
    wait_drained();

    // Random phases; magic alternates, forced on in phase 4. Phase 2 holds the
    // receiver off to fill the block; phase 4 runs with no idling at all.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      write_magic((phase % 2 == 1) || (phase == 4));
      no_idle = (phase == 4);
      if (phase == 2) hold_request = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_random_pattern();
      in_valid <= 1'b0;
      wait_drained();
      no_idle = 1'b0;
    end

    repeat (END_SLACK) @(posedge clk_i);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ search_pattern_escape_mapper.f @@
rtl/core/spm_pkg.sv
rtl/core/spm_front.sv
rtl/core/spm_queue.sv
rtl/core/spm_back.sv
rtl/core/search_pattern_escape_mapper.sv
rtl/core/spm_checker.sv
tb/sv/tb_top.sv
